// ----- sv/tpm_pkg.sv -----
// ----------------------------------------------------------------------------
// Tile to pixel pattern mapper package
// Shared types, codes and field widths for the tile to pixel pattern mapper.
// ----------------------------------------------------------------------------
package tpm_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_WALK,
      ST_MUL,
      ST_SAT
   } state_type;

   localparam logic KIND_LOAD    = 1'b0;
   localparam logic KIND_CONVERT = 1'b1;

   localparam logic [1:0] SEL_COL_WIDTH  = 2'd0;
   localparam logic [1:0] SEL_COL_HEIGHT = 2'd1;
   localparam logic [1:0] SEL_ROW_WIDTH  = 2'd2;
   localparam logic [1:0] SEL_ROW_HEIGHT = 2'd3;

   localparam logic CSR_COLUMN_COUNT = 1'b0;
   localparam logic CSR_ROW_COUNT    = 1'b1;

   localparam int COORD_W   = 16;
   localparam int ENTRY_W   = 16;
   localparam int INDEX_W   = 4;
   localparam int COUNT_W   = 5;
   localparam int PIXEL_W   = 32;
   localparam int DIV_STEPS = 16;

   localparam int REQ_DATA_W = 56;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 64;

   localparam logic [2:0] MUL_LAST = 3'd4;

   localparam logic [PIXEL_W-1:0] PIXEL_MAX = 32'h7fff_ffff;
   localparam logic [PIXEL_W-1:0] PIXEL_MIN = 32'h8000_0000;

endpackage

// ----- sv/tile_to_pixel_pattern_mapper.sv -----
// ----------------------------------------------------------------------------
// Tile to pixel pattern mapper
// Converts tile coordinates to saturated pixel coordinates using four
// repeating column and row offset tables.
// ----------------------------------------------------------------------------
// A load beat writes one offset table entry and gives no result. A convert
// beat runs a one-bit-per-cycle divider on both coordinates, walks the table
// entries up to the larger of the two clamped pattern counts while the prefix
// sums are taken, and then passes the four period totals through the single
// shared multiplier that scales them. The input is not ready while a convert
// is in progress. A finished result waits in the output register, so the next
// beat may be accepted before it is taken.
module tile_to_pixel_pattern_mapper #(
   parameter int MAX_COLUMNS = 16,
   parameter int MAX_ROWS    = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // entry_index [3:0], entry_value [19:4], tile_x [35:20], tile_y [51:36]
   input  logic [tpm_pkg::REQ_DATA_W-1:0]   req_tdata,
   // kind [0], table_select [2:1]
   input  logic [tpm_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // pixel_x [31:0], pixel_y [63:32]
   output logic [tpm_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // saturated [0]
   output logic                             rsp_tuser,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic                             csr_index,
   input  logic [tpm_pkg::COUNT_W-1:0]      csr_data
);

   localparam int MAX_N   = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
   localparam int CNT_W   = ($clog2(MAX_N + 1) > tpm_pkg::COUNT_W) ?
                            $clog2(MAX_N + 1) : tpm_pkg::COUNT_W;
   localparam int COL_IW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int ROW_IW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int SUM_W   = tpm_pkg::ENTRY_W + $clog2(MAX_N) + 1;
   localparam int PROD_W  = tpm_pkg::COORD_W + 1 + SUM_W;
   localparam int ACC_W   = PROD_W + 2;
   localparam int DCNT_W  = $clog2(tpm_pkg::DIV_STEPS);

   // Input field views.
   logic                                req_kind;
   logic [1:0]                          req_table_select;
   logic [tpm_pkg::INDEX_W-1:0]         req_entry_index;
   logic signed [tpm_pkg::ENTRY_W-1:0]  req_entry_value;
   logic [tpm_pkg::COORD_W-1:0]         req_tile_x;
   logic [tpm_pkg::COORD_W-1:0]         req_tile_y;

   assign req_kind         = req_tuser[0];
   assign req_table_select = req_tuser[2:1];
   assign req_entry_index  = req_tdata[3:0];
   assign req_entry_value  = req_tdata[19:4];
   assign req_tile_x       = req_tdata[35:20];
   assign req_tile_y       = req_tdata[51:36];

   // Control and configuration state.
   tpm_pkg::state_type            state_ff, state_in;
   logic [tpm_pkg::COUNT_W-1:0]   col_count_ff;
   logic [tpm_pkg::COUNT_W-1:0]   row_count_ff;
   logic                          rsp_valid_ff, rsp_valid_in;

   // Offset tables.
   logic signed [tpm_pkg::ENTRY_W-1:0] col_w_ff [MAX_COLUMNS];
   logic signed [tpm_pkg::ENTRY_W-1:0] col_h_ff [MAX_COLUMNS];
   logic signed [tpm_pkg::ENTRY_W-1:0] row_w_ff [MAX_ROWS];
   logic signed [tpm_pkg::ENTRY_W-1:0] row_h_ff [MAX_ROWS];

   // Datapath registers.
   logic [tpm_pkg::COORD_W-1:0]   qx_ff, qx_in, qy_ff, qy_in;
   logic [CNT_W-1:0]              rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   logic [DCNT_W-1:0]             div_cnt_ff, div_cnt_in;
   logic [CNT_W-1:0]              step_ff, step_in;
   logic [2:0]                    mstep_ff, mstep_in;
   logic signed [SUM_W-1:0]       cwt_ff, cwt_in, cwp_ff, cwp_in;
   logic signed [SUM_W-1:0]       cht_ff, cht_in, chp_ff, chp_in;
   logic signed [SUM_W-1:0]       rwt_ff, rwt_in, rwp_ff, rwp_in;
   logic signed [SUM_W-1:0]       rht_ff, rht_in, rhp_ff, rhp_in;
   logic signed [PROD_W-1:0]      prod_ff, prod_in;
   logic                          prod_y_ff, prod_y_in;
   logic signed [ACC_W-1:0]       acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic [tpm_pkg::PIXEL_W-1:0]   pixel_x_ff, pixel_x_in, pixel_y_ff, pixel_y_in;
   logic                          sat_ff, sat_in;

   // Working signals.
   logic [CNT_W-1:0]              col_raw, row_raw, cc, rc, max_cnt;
   logic [CNT_W:0]                rem_x_sh, rem_y_sh;
   logic                          qbit_x, qbit_y;
   logic                          col_on, row_on, col_part, row_part;
   logic signed [tpm_pkg::ENTRY_W-1:0] cw_rd, ch_rd, rw_rd, rh_rd;
   logic [tpm_pkg::COORD_W-1:0]   mul_q;
   logic signed [tpm_pkg::COORD_W:0]   mul_qs;
   logic signed [SUM_W-1:0]       mul_t;
   logic                          fit_x, fit_y;
   logic                          load_we;

   assign csr_ready = 1'b1;
   assign load_we   = req_tvalid && req_tready && (req_kind == tpm_pkg::KIND_LOAD);

   // Pattern counts: zero is taken as one, anything above the table depth as the depth.
   assign col_raw = CNT_W'(col_count_ff);
   assign row_raw = CNT_W'(row_count_ff);
   assign cc = (col_raw == '0) ? CNT_W'(1) :
               (col_raw > CNT_W'(MAX_COLUMNS)) ? CNT_W'(MAX_COLUMNS) : col_raw;
   assign rc = (row_raw == '0) ? CNT_W'(1) :
               (row_raw > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : row_raw;
   assign max_cnt = (cc > rc) ? cc : rc;

   // Restoring divider, one quotient bit per cycle on each axis.
   assign rem_x_sh = {rem_x_ff, qx_ff[tpm_pkg::COORD_W-1]};
   assign rem_y_sh = {rem_y_ff, qy_ff[tpm_pkg::COORD_W-1]};
   assign qbit_x   = (rem_x_sh >= {1'b0, cc});
   assign qbit_y   = (rem_y_sh >= {1'b0, rc});

   // Table walk read port.
   assign col_on   = (step_ff < cc);
   assign row_on   = (step_ff < rc);
   assign col_part = (step_ff < rem_x_ff);
   assign row_part = (step_ff < rem_y_ff);
   assign cw_rd = col_on ? col_w_ff[step_ff[COL_IW-1:0]] : '0;
   assign ch_rd = col_on ? col_h_ff[step_ff[COL_IW-1:0]] : '0;
   assign rw_rd = row_on ? row_w_ff[step_ff[ROW_IW-1:0]] : '0;
   assign rh_rd = row_on ? row_h_ff[step_ff[ROW_IW-1:0]] : '0;

   // Shared multiplier operand selection.
   always_comb begin
      unique case (mstep_ff[1:0])
         2'd0: begin
            mul_q = qx_ff;
            mul_t = cwt_ff;
         end
         2'd1: begin
            mul_q = qy_ff;
            mul_t = rwt_ff;
         end
         2'd2: begin
            mul_q = qx_ff;
            mul_t = cht_ff;
         end
         default: begin
            mul_q = qy_ff;
            mul_t = rht_ff;
         end
      endcase
   end

   assign mul_qs  = {1'b0, mul_q};
   assign prod_in = mul_qs * mul_t;

   assign fit_x = (acc_x_ff[ACC_W-1:tpm_pkg::PIXEL_W-1] == '0) ||
                  (acc_x_ff[ACC_W-1:tpm_pkg::PIXEL_W-1] == '1);
   assign fit_y = (acc_y_ff[ACC_W-1:tpm_pkg::PIXEL_W-1] == '0) ||
                  (acc_y_ff[ACC_W-1:tpm_pkg::PIXEL_W-1] == '1);

   always_comb begin
      state_in     = state_ff;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      rem_x_in     = rem_x_ff;
      rem_y_in     = rem_y_ff;
      div_cnt_in   = div_cnt_ff;
      step_in      = step_ff;
      mstep_in     = mstep_ff;
      cwt_in       = cwt_ff;
      cwp_in       = cwp_ff;
      cht_in       = cht_ff;
      chp_in       = chp_ff;
      rwt_in       = rwt_ff;
      rwp_in       = rwp_ff;
      rht_in       = rht_ff;
      rhp_in       = rhp_ff;
      prod_y_in    = mstep_ff[1];
      acc_x_in     = acc_x_ff;
      acc_y_in     = acc_y_ff;
      pixel_x_in   = pixel_x_ff;
      pixel_y_in   = pixel_y_ff;
      sat_in       = sat_ff;

      unique case (state_ff)
         tpm_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid && (req_kind == tpm_pkg::KIND_CONVERT)) begin
               qx_in      = req_tile_x;
               qy_in      = req_tile_y;
               rem_x_in   = '0;
               rem_y_in   = '0;
               div_cnt_in = '0;
               state_in   = tpm_pkg::ST_DIV;
            end
         end
         tpm_pkg::ST_DIV: begin
            rem_x_in   = qbit_x ? CNT_W'(rem_x_sh - {1'b0, cc}) : rem_x_sh[CNT_W-1:0];
            rem_y_in   = qbit_y ? CNT_W'(rem_y_sh - {1'b0, rc}) : rem_y_sh[CNT_W-1:0];
            qx_in      = {qx_ff[tpm_pkg::COORD_W-2:0], qbit_x};
            qy_in      = {qy_ff[tpm_pkg::COORD_W-2:0], qbit_y};
            div_cnt_in = div_cnt_ff + DCNT_W'(1);
            if (div_cnt_ff == '1) begin
               step_in  = '0;
               cwt_in   = '0;
               cwp_in   = '0;
               cht_in   = '0;
               chp_in   = '0;
               rwt_in   = '0;
               rwp_in   = '0;
               rht_in   = '0;
               rhp_in   = '0;
               state_in = tpm_pkg::ST_WALK;
            end
         end
         tpm_pkg::ST_WALK: begin
            cwt_in  = cwt_ff + SUM_W'(cw_rd);
            cht_in  = cht_ff + SUM_W'(ch_rd);
            rwt_in  = rwt_ff + SUM_W'(rw_rd);
            rht_in  = rht_ff + SUM_W'(rh_rd);
            if (col_part) begin
               cwp_in = cwp_ff + SUM_W'(cw_rd);
               chp_in = chp_ff + SUM_W'(ch_rd);
            end
            if (row_part) begin
               rwp_in = rwp_ff + SUM_W'(rw_rd);
               rhp_in = rhp_ff + SUM_W'(rh_rd);
            end
            step_in = step_ff + CNT_W'(1);
            if (step_ff == CNT_W'(max_cnt - CNT_W'(1))) begin
               mstep_in = '0;
               state_in = tpm_pkg::ST_MUL;
            end
         end
         tpm_pkg::ST_MUL: begin
            if (mstep_ff == '0) begin
               acc_x_in = ACC_W'(cwp_ff) + ACC_W'(rwp_ff);
               acc_y_in = ACC_W'(chp_ff) + ACC_W'(rhp_ff);
            end else if (prod_y_ff) begin
               acc_y_in = acc_y_ff + ACC_W'(prod_ff);
            end else begin
               acc_x_in = acc_x_ff + ACC_W'(prod_ff);
            end
            mstep_in = mstep_ff + 3'd1;
            if (mstep_ff == tpm_pkg::MUL_LAST) begin
               state_in = tpm_pkg::ST_SAT;
            end
         end
         tpm_pkg::ST_SAT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               pixel_x_in   = fit_x ? acc_x_ff[tpm_pkg::PIXEL_W-1:0] :
                              (acc_x_ff[ACC_W-1] ? tpm_pkg::PIXEL_MIN : tpm_pkg::PIXEL_MAX);
               pixel_y_in   = fit_y ? acc_y_ff[tpm_pkg::PIXEL_W-1:0] :
                              (acc_y_ff[ACC_W-1] ? tpm_pkg::PIXEL_MIN : tpm_pkg::PIXEL_MAX);
               sat_in       = !fit_x || !fit_y;
               state_in     = tpm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tpm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tpm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= tpm_pkg::COUNT_W'(1);
         row_count_ff <= tpm_pkg::COUNT_W'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tpm_pkg::CSR_COLUMN_COUNT: col_count_ff <= csr_data;
            tpm_pkg::CSR_ROW_COUNT:    row_count_ff <= csr_data;
            default:                   col_count_ff <= col_count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int e = 0; e < MAX_COLUMNS; e++) begin
            col_w_ff[e] <= '0;
            col_h_ff[e] <= '0;
         end
         for (int e = 0; e < MAX_ROWS; e++) begin
            row_w_ff[e] <= '0;
            row_h_ff[e] <= '0;
         end
      end else if (load_we) begin
         for (int e = 0; e < MAX_COLUMNS; e++) begin
            if (int'(req_entry_index) == e) begin
               if (req_table_select == tpm_pkg::SEL_COL_WIDTH) begin
                  col_w_ff[e] <= req_entry_value;
               end
               if (req_table_select == tpm_pkg::SEL_COL_HEIGHT) begin
                  col_h_ff[e] <= req_entry_value;
               end
            end
         end
         for (int e = 0; e < MAX_ROWS; e++) begin
            if (int'(req_entry_index) == e) begin
               if (req_table_select == tpm_pkg::SEL_ROW_WIDTH) begin
                  row_w_ff[e] <= req_entry_value;
               end
               if (req_table_select == tpm_pkg::SEL_ROW_HEIGHT) begin
                  row_h_ff[e] <= req_entry_value;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      qx_ff      <= qx_in;
      qy_ff      <= qy_in;
      rem_x_ff   <= rem_x_in;
      rem_y_ff   <= rem_y_in;
      div_cnt_ff <= div_cnt_in;
      step_ff    <= step_in;
      mstep_ff   <= mstep_in;
      cwt_ff     <= cwt_in;
      cwp_ff     <= cwp_in;
      cht_ff     <= cht_in;
      chp_ff     <= chp_in;
      rwt_ff     <= rwt_in;
      rwp_ff     <= rwp_in;
      rht_ff     <= rht_in;
      rhp_ff     <= rhp_in;
      prod_ff    <= prod_in;
      prod_y_ff  <= prod_y_in;
      acc_x_ff   <= acc_x_in;
      acc_y_ff   <= acc_y_in;
      pixel_x_ff <= pixel_x_in;
      pixel_y_ff <= pixel_y_in;
      sat_ff     <= sat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {pixel_y_ff, pixel_x_ff};
   assign rsp_tuser  = sat_ff;

   // A load beat never produces a result.
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_kind == tpm_pkg::KIND_LOAD) && !rsp_tvalid)
      |=> !rsp_tvalid)
      else $error("result raised after a load beat");

   // The divider remainders stay below their divisors.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tpm_pkg::ST_DIV) |-> ((rem_x_ff < cc) && (rem_y_ff < rc)))
      else $error("divider remainder out of range");

   // The table walk never runs past the longer pattern.
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tpm_pkg::ST_WALK) |-> (step_ff < max_cnt))
      else $error("table walk beyond pattern length");

   // A result only appears as the saturation step completes.
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == tpm_pkg::ST_SAT))
      else $error("result raised outside the saturation step");

endmodule
